// ===== hw/rtl/mce_pkg.sv =====
// Shared types and constants of the mask centroid and extent block.
// Holds the configuration and job structs and the fixed field widths.
// No dependencies.
package mce_pkg;

    localparam int SUM_W      = 27;
    localparam int TALLY_W    = 17;
    localparam int CENTRE_W   = 12;
    localparam int EXT_W      = 9;
    localparam int SIZE_W     = 9;
    localparam int POS_W      = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 2'd3;

    localparam logic [POS_W-1:0]    LEFT_RESET   = 10'd0;
    localparam logic [POS_W-1:0]    TOP_RESET    = 10'd0;
    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 9'd256;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 9'd256;

    localparam logic [CENTRE_W-1:0] NONE_CENTRE  = 12'hFFF;

    typedef struct packed {
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [TALLY_W-1:0] tally;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   top;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } job_t;

endpackage

// ===== hw/rtl/mce_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/mce_fifo.sv =====
// Two-entry job queue between the pixel front end and the result back end.
// Depends on mce_pkg.
module mce_fifo
    import mce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t pop_data,
    output logic empty,
    output logic full
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mce_div.sv =====
// Restoring divider, one quotient bit per cycle, for the centroid sums.
// Depends on mce_pkg.
module mce_div
    import mce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [TALLY_W-1:0] divisor,
    output logic               done,
    output logic [SUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   quot_reg;
    logic [TALLY_W-1:0] rem_reg;
    logic [TALLY_W-1:0] divisor_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [TALLY_W:0]   shifted;
    logic [TALLY_W:0]   trial;
    logic               fits;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[SUM_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? trial[TALLY_W-1:0] : shifted[TALLY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mce_front.sv =====
// Pixel front end: takes mask items, writes the mask store, sums coordinates,
// tracks the raster position and queues one job per frame. Depends on mce_pkg.
module mce_front
    import mce_pkg::*;
#(
    parameter int MAX_W      = 256,
    parameter int MAX_H      = 256,
    parameter int COORD_BITS = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfg_t                               cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mask_bit,
    output logic                               ram_we,
    output logic [$clog2(MAX_W*MAX_H)-1:0]     ram_waddr,
    output logic                               ram_wdata,
    output logic                               q_push,
    output job_t                               q_data,
    input  logic                               back_done
);

    localparam int COL_W  = $clog2(MAX_W);
    localparam int ROW_W  = $clog2(MAX_H);
    localparam int ADDR_W = $clog2(MAX_W * MAX_H);
    localparam int XY_W   = 16;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic               hold_reg;

    logic [SIZE_W-1:0]  w_clamp;
    logic [SIZE_W-1:0]  h_clamp;
    logic [XY_W-1:0]    x_pos;
    logic [XY_W-1:0]    y_pos;
    logic [SUM_W-1:0]   sum_x_next;
    logic [SUM_W-1:0]   sum_y_next;
    logic [TALLY_W-1:0] tally_next;
    logic               accept;
    logic               last_col;
    logic               last_row;
    logic               frame_end;

    always_comb
    begin
        if (cfg.width == '0)
            w_clamp = SIZE_W'(1);
        else if (int'(cfg.width) > MAX_W)
            w_clamp = SIZE_W'(MAX_W);
        else
            w_clamp = cfg.width;

        if (cfg.height == '0)
            h_clamp = SIZE_W'(1);
        else if (int'(cfg.height) > MAX_H)
            h_clamp = SIZE_W'(MAX_H);
        else
            h_clamp = cfg.height;

        x_pos = XY_W'(cfg.left) + XY_W'(col_reg);
        y_pos = XY_W'(cfg.top) + XY_W'(row_reg);

        if (mask_bit)
        begin
            sum_x_next = sum_x_reg + SUM_W'(x_pos[COORD_BITS-1:0]);
            sum_y_next = sum_y_reg + SUM_W'(y_pos[COORD_BITS-1:0]);
            tally_next = tally_reg + TALLY_W'(1);
        end
        else
        begin
            sum_x_next = sum_x_reg;
            sum_y_next = sum_y_reg;
            tally_next = tally_reg;
        end

        accept    = in_valid && !hold_reg;
        last_col  = ((XY_W'(col_reg) + XY_W'(1)) >= XY_W'(w_clamp));
        last_row  = ((XY_W'(row_reg) + XY_W'(1)) >= XY_W'(h_clamp));
        frame_end = accept && last_col && last_row;
    end

    assign in_stall  = hold_reg;
    assign ram_we    = accept;
    assign ram_waddr = row_base_reg + ADDR_W'(col_reg);
    assign ram_wdata = mask_bit;
    assign q_push    = frame_end;

    always_comb
    begin
        q_data.sum_x = sum_x_next;
        q_data.sum_y = sum_y_next;
        q_data.tally = tally_next;
        q_data.left  = cfg.left;
        q_data.top   = cfg.top;
        q_data.w     = w_clamp;
        q_data.h     = h_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            tally_reg    <= '0;
            hold_reg     <= 1'b0;
        end
        else
        begin
            if (back_done)
            begin
                hold_reg <= 1'b0;
            end
            if (accept)
            begin
                if (!last_col)
                begin
                    col_reg   <= col_reg + COL_W'(1);
                    sum_x_reg <= sum_x_next;
                    sum_y_reg <= sum_y_next;
                    tally_reg <= tally_next;
                end
                else if (!last_row)
                begin
                    col_reg      <= '0;
                    row_reg      <= row_reg + ROW_W'(1);
                    row_base_reg <= row_base_reg + ADDR_W'(MAX_W);
                    sum_x_reg    <= sum_x_next;
                    sum_y_reg    <= sum_y_next;
                    tally_reg    <= tally_next;
                end
                else
                begin
                    // frame done: hand off and hold until the result is out
                    col_reg      <= '0;
                    row_reg      <= '0;
                    row_base_reg <= '0;
                    sum_x_reg    <= '0;
                    sum_y_reg    <= '0;
                    tally_reg    <= '0;
                    hold_reg     <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/mce_back.sv =====
// Result back end: divides the sums, scans the centroid row and column of the
// mask store, and holds the result item. Depends on mce_pkg and mce_div.
module mce_back
    import mce_pkg::*;
#(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  job_t                           q_data,
    output logic                           q_pop,
    output logic                           ram_re,
    output logic [$clog2(MAX_W*MAX_H)-1:0] ram_raddr,
    input  logic                           ram_rdata,
    output logic                           back_done,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [TALLY_W-1:0]             set_count,
    output logic signed [CENTRE_W-1:0]     centre_x,
    output logic signed [CENTRE_W-1:0]     centre_y,
    output logic [EXT_W-1:0]               extent_width,
    output logic [EXT_W-1:0]               extent_height
);

    localparam int COL_W  = $clog2(MAX_W);
    localparam int ROW_W  = $clog2(MAX_H);
    localparam int ADDR_W = $clog2(MAX_W * MAX_H);
    localparam int DIFF_W = SUM_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_SETUP,
        ST_ROW,
        ST_COL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic [SUM_W-1:0]   qx_reg;
    logic [SUM_W-1:0]   qy_reg;
    logic               div_start_reg;
    logic               row_ok_reg;
    logic               col_ok_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  col_start_reg;
    logic [SIZE_W-1:0]  idx_reg;
    logic               rd_pend_reg;
    logic               rd_row_reg;
    logic [EXT_W-1:0]   ew_reg;
    logic [EXT_W-1:0]   eh_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [TALLY_W-1:0] count_reg;
    logic [CENTRE_W-1:0] cx_reg;
    logic [CENTRE_W-1:0] cy_reg;
    logic [EXT_W-1:0]   ow_reg;
    logic [EXT_W-1:0]   oh_reg;

    logic               div_done;
    logic [SUM_W-1:0]   div_quot;
    logic [SUM_W-1:0]   div_dividend;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
    logic               row_ok;
    logic               col_ok;
    logic               out_free;
    logic               job_found;
    logic               idx_last_w;
    logic               idx_last_h;

    mce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (job_reg.tally),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        div_dividend = (state_reg == ST_DIV_Y) ? job_reg.sum_y : job_reg.sum_x;
        dx           = {1'b0, qx_reg} - DIFF_W'(job_reg.left);
        dy           = {1'b0, qy_reg} - DIFF_W'(job_reg.top);
        col_ok       = !dx[DIFF_W-1] && (dx < DIFF_W'(job_reg.w));
        row_ok       = !dy[DIFF_W-1] && (dy < DIFF_W'(job_reg.h));
        out_free     = !out_valid_reg || !out_stall;
        job_found    = (job_reg.tally != '0);
        idx_last_w   = ((POS_W'(idx_reg) + POS_W'(1)) >= POS_W'(job_reg.w));
        idx_last_h   = ((POS_W'(idx_reg) + POS_W'(1)) >= POS_W'(job_reg.h));
    end

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign ram_re    = ((state_reg == ST_ROW) && row_ok_reg) ||
                       ((state_reg == ST_COL) && col_ok_reg);
    assign ram_raddr = addr_reg;
    assign back_done = (state_reg == ST_EMIT) && out_free;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign set_count     = count_reg;
    assign centre_x      = cx_reg;
    assign centre_y      = cy_reg;
    assign extent_width  = ow_reg;
    assign extent_height = oh_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if ((state_reg == ST_DIV_X) && div_done)
        begin
            qx_reg <= div_quot;
        end
        if ((state_reg == ST_DIV_Y) && div_done)
        begin
            qy_reg <= div_quot;
        end
        if (back_done)
        begin
            found_reg <= job_found;
            count_reg <= job_reg.tally;
            cx_reg    <= job_found ? qx_reg[CENTRE_W-1:0] : NONE_CENTRE;
            cy_reg    <= job_found ? qy_reg[CENTRE_W-1:0] : NONE_CENTRE;
            ow_reg    <= job_found ? ew_reg : '0;
            oh_reg    <= job_found ? eh_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            row_ok_reg    <= 1'b0;
            col_ok_reg    <= 1'b0;
            addr_reg      <= '0;
            col_start_reg <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_row_reg    <= 1'b0;
            ew_reg        <= '0;
            eh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            if (rd_pend_reg)
            begin
                if (rd_row_reg)
                    ew_reg <= ew_reg + EXT_W'(ram_rdata);
                else
                    eh_reg <= eh_reg + EXT_W'(ram_rdata);
            end

            if (back_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (q_data.tally == '0)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV_X;
                        end
                    end
                end
                ST_DIV_X:
                begin
                    if (div_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    row_ok_reg    <= row_ok;
                    col_ok_reg    <= col_ok;
                    addr_reg      <= ADDR_W'(dy[ROW_W-1:0]) * ADDR_W'(MAX_W);
                    col_start_reg <= ADDR_W'(dx[COL_W-1:0]);
                    idx_reg       <= '0;
                    ew_reg        <= '0;
                    eh_reg        <= '0;
                    state_reg     <= ST_ROW;
                end
                ST_ROW:
                begin
                    rd_pend_reg <= row_ok_reg;
                    rd_row_reg  <= 1'b1;
                    if (!row_ok_reg || idx_last_w)
                    begin
                        idx_reg   <= '0;
                        addr_reg  <= col_start_reg;
                        state_reg <= ST_COL;
                    end
                    else
                    begin
                        idx_reg  <= idx_reg + SIZE_W'(1);
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end
                ST_COL:
                begin
                    rd_pend_reg <= col_ok_reg;
                    rd_row_reg  <= 1'b0;
                    if (!col_ok_reg || idx_last_h)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg  <= idx_reg + SIZE_W'(1);
                        addr_reg <= addr_reg + ADDR_W'(MAX_W);
                    end
                end
                ST_DRAIN:
                begin
                    rd_pend_reg <= 1'b0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/mask_centroid_and_extent.sv =====
// Top level of the mask centroid and extent block: configuration registers,
// mask store, front end, job queue and back end. Depends on mce_pkg, mce_ram, mce_front, mce_fifo and mce_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   in       | in_valid / in_stall    | mask_bit
//   out      | out_valid / out_stall  | found, set_count, centre_x, centre_y,
//            |                        | extent_width, extent_height
//   cfg      | cfg_wr_en              | cfg_index, cfg_data
//
// Pixels are taken one per cycle while in_stall is low; the mask store write port
// sets that figure. After a frame's last pixel, in_stall stays high through two
// divisions on one divider, then one store read per cycle along the centroid row (w)
// and column (h), plus setup, drain and load. An empty frame skips to the load.
// Reset clears all control state; the mask store is not cleared and needs no pass.
// A waiting result does not block pixels of the next frame; it delays the next load.
module mask_centroid_and_extent
    import mce_pkg::*;
#(
    parameter int MAX_WINDOW_WIDTH  = 256,
    parameter int MAX_WINDOW_HEIGHT = 256,
    parameter int COORD_BITS        = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mask_bit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [TALLY_W-1:0]          set_count,
    output logic signed [CENTRE_W-1:0]  centre_x,
    output logic signed [CENTRE_W-1:0]  centre_y,
    output logic [EXT_W-1:0]            extent_width,
    output logic [EXT_W-1:0]            extent_height
);

    localparam int DEPTH  = MAX_WINDOW_WIDTH * MAX_WINDOW_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t              cfg_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;
    logic              q_push;
    job_t              q_push_data;
    logic              q_pop;
    job_t              q_pop_data;
    logic              q_empty;
    logic              q_full;
    logic              back_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left   <= LEFT_RESET;
            cfg_reg.top    <= TOP_RESET;
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEFT:   cfg_reg.left   <= cfg_data;
                CFG_WINDOW_TOP:    cfg_reg.top    <= cfg_data;
                CFG_WINDOW_WIDTH:  cfg_reg.width  <= cfg_data[SIZE_W-1:0];
                CFG_WINDOW_HEIGHT: cfg_reg.height <= cfg_data[SIZE_W-1:0];
                default:           cfg_reg        <= cfg_reg;
            endcase
        end
    end

    mce_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mce_front #(
        .MAX_W      (MAX_WINDOW_WIDTH),
        .MAX_H      (MAX_WINDOW_HEIGHT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mask_bit  (mask_bit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .back_done (back_done)
    );

    mce_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    mce_back #(
        .MAX_W (MAX_WINDOW_WIDTH),
        .MAX_H (MAX_WINDOW_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .back_done     (back_done),
        .out_valid     (out_valid),
        .out_stall     (out_stall || q_full),
        .found         (found),
        .set_count     (set_count),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .extent_width  (extent_width),
        .extent_height (extent_height)
    );

endmodule

// ===== hw/rtl/mce_checker.sv =====
// Port-level checks of the mask centroid and extent block, bound to its top.
// Depends on mce_pkg.
module mce_checker
    import mce_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic [TALLY_W-1:0]         set_count,
    input logic signed [CENTRE_W-1:0] centre_x,
    input logic signed [CENTRE_W-1:0] centre_y,
    input logic [EXT_W-1:0]           extent_width,
    input logic [EXT_W-1:0]           extent_height
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (set_count == '0) && (centre_x == -1) &&
            (centre_y == -1) && (extent_width == '0) && (extent_height == '0))
        else $error("empty frame result malformed");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> set_count != '0)
        else $error("found with zero count");

    a_extent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (TALLY_W'(extent_width) <= set_count) &&
            (TALLY_W'(extent_height) <= set_count))
        else $error("extent exceeds set pixel count");

endmodule

bind mask_centroid_and_extent mce_checker u_mce_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for mask_centroid_and_extent: streams binary mask frames through
// randomly stalled valid/stall channels and checks each result against a
// local centroid and extent predictor. Depends on mce_pkg and the block's RTL.
module tb_top;
    import mce_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int COORD_RANGE   = 2048;
    localparam int SETTLE_CYCLES = 700;
    localparam int RANDOM_PIXELS = 1400;
    localparam int RANDOM_FRAMES = 16;

    typedef enum int {
        FILL_NONE,
        FILL_ALL,
        FILL_SPARSE,
        FILL_HALF,
        FILL_DENSE,
        FILL_CORNERS,
        FILL_SINGLE
    } fill_t;

    typedef struct {
        bit                found;
        bit [TALLY_W-1:0]  count;
        bit [CENTRE_W-1:0] cx;
        bit [CENTRE_W-1:0] cy;
        bit [EXT_W-1:0]    ew;
        bit [EXT_W-1:0]    eh;
    } blob_t;

    class blob_tracker;
        bit [POS_W-1:0]   left = LEFT_RESET;
        bit [POS_W-1:0]   top = TOP_RESET;
        bit [SIZE_W-1:0]  width = WIDTH_RESET;
        bit [SIZE_W-1:0]  height = HEIGHT_RESET;
        bit               mask_mem [MAX_SIDE*MAX_SIDE];
        bit [SUM_W-1:0]   sum_x = '0;
        bit [SUM_W-1:0]   sum_y = '0;
        bit [TALLY_W-1:0] tally = '0;
        int               col_pos = 0;
        int               row_pos = 0;
        blob_t            expected_blobs [$];
        int unsigned      mismatches = 0;
        int unsigned      checked = 0;

        function int span(bit [SIZE_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return int'(v);
        endfunction

        function int frame_pixels();
            return span(width) * span(height);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WINDOW_LEFT:   left = val;
                CFG_WINDOW_TOP:    top = val;
                CFG_WINDOW_WIDTH:  width = val[SIZE_W-1:0];
                CFG_WINDOW_HEIGHT: height = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(bit b);
            int         w;
            int         h;
            int         c;
            int         r;
            int         rx;
            int         ry;
            bit [SUM_W-1:0] cx;
            bit [SUM_W-1:0] cy;
            blob_t      e;
            w = span(width);
            h = span(height);
            c = (col_pos >= MAX_SIDE) ? MAX_SIDE - 1 : col_pos;
            r = (row_pos >= MAX_SIDE) ? MAX_SIDE - 1 : row_pos;
            mask_mem[r*MAX_SIDE + c] = b;
            if (b)
            begin
                sum_x = sum_x + SUM_W'((int'(left) + c) % COORD_RANGE);
                sum_y = sum_y + SUM_W'((int'(top) + r) % COORD_RANGE);
                tally = tally + TALLY_W'(1);
            end
            if (c + 1 < w)
            begin
                col_pos = c + 1;
                row_pos = r;
                return;
            end
            col_pos = 0;
            if (r + 1 < h)
            begin
                row_pos = r + 1;
                return;
            end
            row_pos = 0;

            e.found = 1'b0;
            e.count = tally;
            e.cx = NONE_CENTRE;
            e.cy = NONE_CENTRE;
            e.ew = '0;
            e.eh = '0;
            if (tally != 0)
            begin
                e.found = 1'b1;
                cx = sum_x / tally;
                cy = sum_y / tally;
                e.cx = cx[CENTRE_W-1:0];
                e.cy = cy[CENTRE_W-1:0];
                rx = int'(cx) - int'(left);
                ry = int'(cy) - int'(top);
                if (ry >= 0 && ry < h)
                    for (int i = 0; i < w; i++)
                        e.ew = e.ew + EXT_W'(mask_mem[ry*MAX_SIDE + i]);
                if (rx >= 0 && rx < w)
                    for (int i = 0; i < h; i++)
                        e.eh = e.eh + EXT_W'(mask_mem[i*MAX_SIDE + rx]);
            end
            expected_blobs.push_back(e);
            sum_x = '0;
            sum_y = '0;
            tally = '0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 checked, name, got, want));
        endtask

        task check_blob(bit f, bit [TALLY_W-1:0] n, bit [CENTRE_W-1:0] x,
                        bit [CENTRE_W-1:0] y, bit [EXT_W-1:0] ew, bit [EXT_W-1:0] eh);
            blob_t e;
            if (expected_blobs.size() == 0)
            begin
                report($sformatf("result with none expected (count %0d)", n));
                return;
            end
            e = expected_blobs.pop_front();
            checked++;
            compare_field("found", f, e.found);
            compare_field("set_count", n, e.count);
            compare_field("centre_x", x, e.cx);
            compare_field("centre_y", y, e.cy);
            compare_field("extent_width", ew, e.ew);
            compare_field("extent_height", eh, e.eh);
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_WINDOW_LEFT;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        mask_bit = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        found;
    logic [TALLY_W-1:0]          set_count;
    logic signed [CENTRE_W-1:0]  centre_x;
    logic signed [CENTRE_W-1:0]  centre_y;
    logic [EXT_W-1:0]            extent_width;
    logic [EXT_W-1:0]            extent_height;

    bit          gaps_on = 1'b0;
    int unsigned pixels_sent = 0;
    int unsigned frames_sent = 0;
    blob_tracker blobs;

    mask_centroid_and_extent uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mask_bit      (mask_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .set_count     (set_count),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .extent_width  (extent_width),
        .extent_height (extent_height)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            blobs.check_blob(found, set_count, centre_x, centre_y,
                             extent_width, extent_height);
        out_stall <= gaps_on && ($urandom_range(99) < 18);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        blobs.set_reg(idx, val);
    endtask

    task automatic set_window(input bit move, input logic [CFG_DATA_W-1:0] l, t, w, h);
        if (move)
        begin
            write_reg(CFG_WINDOW_LEFT, l);
            write_reg(CFG_WINDOW_TOP, t);
        end
        write_reg(CFG_WINDOW_WIDTH, w);
        write_reg(CFG_WINDOW_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input bit b);
        while (gaps_on && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mask_bit <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        blobs.note_pixel(b);
        pixels_sent++;
    endtask

    task automatic send_frame(input fill_t fill);
        int n;
        int spot;
        bit b;
        n = blobs.frame_pixels();
        spot = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
        begin
            case (fill)
                FILL_NONE:    b = 1'b0;
                FILL_ALL:     b = 1'b1;
                FILL_SPARSE:  b = $urandom_range(99) < 10;
                FILL_HALF:    b = 1'($urandom_range(1));
                FILL_DENSE:   b = $urandom_range(99) < 90;
                FILL_CORNERS: b = (i == 0) || (i == n - 1);
                default:      b = (i == spot);
            endcase
            send_pixel(b);
        end
        frames_sent++;
    endtask

    // drain results, then let the back end finish before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (blobs.expected_blobs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned base;
        int          frames;
        int          a;
        int          b;
        int          span_a;
        int          lim;
        blobs = new;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        set_window(1'b1, 10'd0, 10'd0, 10'd1, 10'd1);
        send_frame(FILL_NONE);
        send_frame(FILL_ALL);
        settle();

        set_window(1'b1, 10'd1023, 10'd1023, 10'd0, 10'd0);
        send_frame(FILL_ALL);
        settle();

        set_window(1'b0, 10'd0, 10'd0, 10'd3, 10'd3);
        send_frame(FILL_CORNERS);
        send_frame(FILL_ALL);
        send_frame(FILL_SINGLE);
        settle();

        set_window(1'b1, 10'd0, 10'd5, 10'd300, 10'd1);
        send_frame(FILL_HALF);
        settle();

        set_window(1'b1, 10'd700, 10'd0, 10'h201, 10'h1FF);
        send_frame(FILL_HALF);
        settle();

        base = pixels_sent;
        frames = 0;
        while (pixels_sent - base < RANDOM_PIXELS || frames < RANDOM_FRAMES)
        begin
            case ($urandom_range(9))
                0:       a = 0;
                1:       a = $urandom_range(257, 511);
                2, 3:    a = $urandom_range(13, 64);
                default: a = $urandom_range(1, 12);
            endcase
            span_a = (a == 0) ? 1 : (a > MAX_SIDE) ? MAX_SIDE : a;
            lim = 300 / span_a;
            if (lim <= 1)
                b = $urandom_range(1);
            else if ($urandom_range(9) == 0)
                b = 0;
            else
                b = $urandom_range(1, (lim > 12) ? 12 : lim);
            if ($urandom_range(1))
                set_window(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(1023)),
                           CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'(b),
                           CFG_DATA_W'(a));
            else
                set_window(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(1023)),
                           CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'(a),
                           CFG_DATA_W'(b));
            repeat ($urandom_range(1, 4))
            begin
                gaps_on = !(frames >= 4 && frames < 12);
                send_frame(fill_t'($urandom_range(FILL_SINGLE)));
                frames++;
            end
            settle();
        end

        $display("Ran %0d frames (%0d mask pixels) over directed and random windows;",
                 frames_sent, pixels_sent);
        $display("%0d results checked, %0d mismatches.", blobs.checked, blobs.mismatches);
        if (blobs.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #16000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mce_pkg.sv
hw/rtl/mce_ram.sv
hw/rtl/mce_fifo.sv
hw/rtl/mce_div.sv
hw/rtl/mce_front.sv
hw/rtl/mce_back.sv
hw/rtl/mask_centroid_and_extent.sv
hw/rtl/mce_checker.sv
sim/tb_top.sv
